// ----- rtl/load_store_unit_assert.svh -----
// Assertion macros for the load/store unit checker.
`ifndef LOAD_STORE_UNIT_ASSERT_SVH
`define LOAD_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("load_store_unit: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("load_store_unit: assertion failed");

`endif

// ----- rtl/lsu_pkg.sv -----
// Shared constants and types for the load/store unit.
package lsu_pkg;

    // Default data memory size in bytes.
    localparam int unsigned LSU_MEM_BYTES = 65536;

    // Memory is organized as eight byte lanes.
    localparam int unsigned LSU_LANES = 8;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 2'd1;

    // Region size register width and reset value.
    localparam int unsigned REGION_SIZE_W = 17;
    localparam logic [REGION_SIZE_W-1:0] REGION_SIZE_RST = 17'd65536;

    // Transaction kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    // Result status codes.
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_FAULT = 1'b1;

    // Access size codes.
    typedef enum logic [1:0] {
        SZ_BYTE   = 2'd0,
        SZ_HALF   = 2'd1,
        SZ_WORD   = 2'd2,
        SZ_DOUBLE = 2'd3
    } t_size;

endpackage

// ----- rtl/lsu_ram.sv -----
// Generic single-port RAM with registered read data.
module lsu_ram
    import lsu_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = LSU_MEM_BYTES / LSU_LANES,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write into the array; read data is registered and shows the old word on a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ----- rtl/load_store_unit.sv -----
// Load/store unit top level: address check, byte-lane data memory, result register.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one load or store transaction.
//   Output channel (o_valid/i_ready) returns one result per transaction.
//   Config channel (i_cfg_valid/o_cfg_ready) writes region_base (index 0) and
//   region_size (index 1); it is always ready. Write it only while idle.
// Sequence: an accepted transaction passes the address, bound, check and access
//   states; a load that does not fault adds a data state before its result is
//   pushed to the output register. The sequencer in front of the single-ported
//   byte-lane memory handles one transaction at a time and keeps o_ready low
//   until the result is pushed.
// Reset: synchronous, active low. After reset the unit sweeps the memory to
//   zero, one row of eight bytes per cycle, during which o_ready stays low.
//   Config writes are taken.
// Stall: the result waits in the output register while i_ready is low; the
//   unit still accepts and works on the next transaction, then holds its
//   result until the output register frees up.
module load_store_unit
    import lsu_pkg::*;
#(
    parameter int unsigned MEM_BYTES = LSU_MEM_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_kind,
    input  logic [1:0]               i_size_code,
    input  logic                     i_sign_extend,
    input  logic [63:0]              i_base_value,
    input  logic signed [11:0]       i_offset,
    input  logic [63:0]              i_store_data,
    input  logic [4:0]               i_dest_reg,
    // result channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_status,
    output logic [63:0]              o_load_value,
    output logic                     o_write_enable,
    output logic [4:0]               o_write_reg,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]              i_cfg_data
);

    localparam int unsigned ROWS = (MEM_BYTES + LSU_LANES - 1) / LSU_LANES;
    localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [63:0] MEM_BYTES_W = 64'(MEM_BYTES);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_ADDR   = 8'b0000_0100,
        ST_BOUND  = 8'b0000_1000,
        ST_CHECK  = 8'b0001_0000,
        ST_ACCESS = 8'b0010_0000,
        ST_DATA   = 8'b0100_0000,
        ST_PUSH   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [RW-1:0] r_clr_row;

    // configuration registers
    logic [63:0]              r_region_base;
    logic [REGION_SIZE_W-1:0] r_region_size;

    // captured transaction
    logic        r_kind;
    logic [1:0]  r_size_code;
    logic        r_sign_extend;
    logic [63:0] r_base_value;
    logic [11:0] r_offset;
    logic [63:0] r_store_data;
    logic [4:0]  r_dest_reg;

    // address pipeline
    logic [63:0] r_ea;
    logic [63:0] r_limit;
    logic [64:0] r_end;
    logic [64:0] r_idx;
    logic        r_fault;
    logic [64:0] limit_sum;
    logic [3:0]  nbytes;

    // pending result
    logic        r_res_status;
    logic [63:0] r_res_value;
    logic        r_res_we;
    logic [4:0]  r_res_reg;

    // output register
    logic        r_o_valid;
    logic        r_o_status;
    logic [63:0] r_o_value;
    logic        r_o_we;
    logic [4:0]  r_o_reg;

    // byte lanes
    logic [LSU_LANES-1:0] lane_we;
    logic [RW-1:0]        lane_addr  [LSU_LANES];
    logic [7:0]           lane_wdata [LSU_LANES];
    logic [7:0]           lane_rdata [LSU_LANES];
    logic [2:0]           lane_sel   [LSU_LANES];
    logic [RW-1:0]        row;
    logic [2:0]           lo;

    logic        in_fire;
    logic        out_fire;
    logic        push;
    logic [63:0] raw;
    logic [63:0] ext;

    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_o_valid && i_ready;
    assign push     = (r_state == ST_PUSH) && (!r_o_valid || i_ready);
    assign nbytes   = 4'd1 << r_size_code;
    assign row      = r_idx[RW+2:3];
    assign lo       = r_idx[2:0];
    assign limit_sum = {1'b0, r_region_base} + 65'(r_region_size);

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (r_clr_row == LAST_ROW) n_state = ST_IDLE;
            ST_IDLE:   if (in_fire) n_state = ST_ADDR;
            ST_ADDR:   n_state = ST_BOUND;
            ST_BOUND:  n_state = ST_CHECK;
            ST_CHECK:  n_state = ST_ACCESS;
            ST_ACCESS: begin
                if (!r_fault && r_kind == KIND_LOAD) n_state = ST_DATA;
                else n_state = ST_PUSH;
            end
            ST_DATA:   n_state = ST_PUSH;
            ST_PUSH:   if (push) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // Lane addressing and write steering; an unaligned access spills into the next row
    always_comb begin
        for (int b = 0; b < LSU_LANES; b++) begin
            lane_sel[b]   = 3'(b) - lo;
            lane_addr[b]  = row + RW'(3'(b) < lo);
            lane_wdata[b] = r_store_data[{lane_sel[b], 3'b000} +: 8];
            lane_we[b]    = (r_state == ST_ACCESS) && !r_fault && (r_kind == KIND_STORE)
                            && ({1'b0, lane_sel[b]} < nbytes);
            if (r_state == ST_CLEAR) begin
                lane_addr[b]  = r_clr_row;
                lane_wdata[b] = 8'd0;
                lane_we[b]    = 1'b1;
            end
        end
    end

    for (genvar g = 0; g < LSU_LANES; g++) begin : g_lane
        lsu_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (lane_we[g]),
            .i_addr  (lane_addr[g]),
            .i_wdata (lane_wdata[g]),
            .o_rdata (lane_rdata[g])
        );
    end

    // Rotate read lanes back into byte order, then extend
    always_comb begin
        for (int i = 0; i < LSU_LANES; i++) begin
            raw[8*i +: 8] = lane_rdata[3'(i) + lo];
        end
        case (t_size'(r_size_code))
            SZ_BYTE:   ext = {{56{r_sign_extend & raw[7]}},  raw[7:0]};
            SZ_HALF:   ext = {{48{r_sign_extend & raw[15]}}, raw[15:0]};
            SZ_WORD:   ext = {{32{r_sign_extend & raw[31]}}, raw[31:0]};
            SZ_DOUBLE: ext = raw;
            default:   ext = raw;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_row     <= '0;
            r_region_base <= '0;
            r_region_size <= REGION_SIZE_RST;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_row <= r_clr_row + RW'(1);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_REGION_BASE: r_region_base <= i_cfg_data;
                    REG_REGION_SIZE: r_region_size <= i_cfg_data[REGION_SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (push) r_o_valid <= 1'b1;
            else if (out_fire) r_o_valid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind        <= i_kind;
            r_size_code   <= i_size_code;
            r_sign_extend <= i_sign_extend;
            r_base_value  <= i_base_value;
            r_offset      <= i_offset;
            r_store_data  <= i_store_data;
            r_dest_reg    <= i_dest_reg;
        end
        // effective address and saturated region limit
        if (r_state == ST_ADDR) begin
            r_ea    <= r_base_value + {{52{r_offset[11]}}, r_offset};
            r_limit <= limit_sum[64] ? '1 : limit_sum[63:0];
        end
        // end address with carry, region offset with borrow
        if (r_state == ST_BOUND) begin
            r_end <= {1'b0, r_ea} + 65'(nbytes);
            r_idx <= {1'b0, r_ea} - {1'b0, r_region_base};
        end
        if (r_state == ST_CHECK) begin
            r_fault <= r_end[64] || r_idx[64] || (r_end[63:0] > r_limit)
                       || (r_idx[63:0] > (MEM_BYTES_W - 64'(nbytes)));
        end
        // fault and store results
        if (r_state == ST_ACCESS) begin
            r_res_status <= r_fault ? STATUS_FAULT : STATUS_DONE;
            r_res_value  <= '0;
            r_res_we     <= 1'b0;
            r_res_reg    <= '0;
        end
        // load result
        if (r_state == ST_DATA) begin
            r_res_status <= STATUS_DONE;
            r_res_value  <= ext;
            r_res_we     <= (r_dest_reg != 5'd0);
            r_res_reg    <= r_dest_reg;
        end
        if (push) begin
            r_o_status <= r_res_status;
            r_o_value  <= r_res_value;
            r_o_we     <= r_res_we;
            r_o_reg    <= r_res_reg;
        end
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_load_value   = r_o_value;
    assign o_write_enable = r_o_we;
    assign o_write_reg    = r_o_reg;
    assign o_cfg_ready    = 1'b1;

endmodule

// ----- rtl/lsu_checker.sv -----
// Port-level checker for the load/store unit, bound to the top level.
`include "load_store_unit_assert.svh"
module lsu_checker
    import lsu_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_status,
    input logic [63:0] o_load_value,
    input logic        o_write_enable,
    input logic [4:0]  o_write_reg
);

    logic [1:0] r_pending;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = i_valid && o_ready;
    assign out_fire = o_valid && i_ready;

    // Transactions accepted but not yet returned
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(in_fire) - 2'(out_fire);
        end
    end

    `LSU_ASSERT_NOW(a_fault_clean, i_clk, i_rst_n, o_valid && (o_status == STATUS_FAULT), (o_load_value == 64'd0) && !o_write_enable && (o_write_reg == 5'd0))
    `LSU_ASSERT_NOW(a_we_valid, i_clk, i_rst_n, o_valid && o_write_enable, (o_status == STATUS_DONE) && (o_write_reg != 5'd0))
    `LSU_ASSERT_NOW(a_no_orphan, i_clk, i_rst_n, o_valid, r_pending != 2'd0)
    `LSU_ASSERT_NOW(a_one_in_flight, i_clk, i_rst_n, in_fire, r_pending <= 2'd1)
    `LSU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_load_value) && $stable(o_status))

endmodule

bind load_store_unit lsu_checker u_lsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_load_value   (o_load_value),
    .o_write_enable (o_write_enable),
    .o_write_reg    (o_write_reg)
);

// ----- bench/lsu_tb_pkg.sv -----
// Transaction types and scoreboard for the load/store unit testbench.
package lsu_tb_pkg;
    import lsu_pkg::*;

    // One load or store request as seen on the input channel.
    typedef struct {
        logic             kind;
        t_size            size;
        logic             sext;
        logic [63:0]      base;
        logic signed [11:0] offset;
        logic [63:0]      sdata;
        logic [4:0]       rd;
    } lsu_req_t;

    // One result as seen on the output channel.
    typedef struct {
        logic        status;
        logic [63:0] value;
        logic        we;
        logic [4:0]  wreg;
    } lsu_resp_t;

    class lsu_scoreboard;
        bit [7:0]          shadow_mem [LSU_MEM_BYTES];
        logic [63:0]       region_base;
        logic [16:0]       region_size;
        lsu_resp_t         pending_outcomes [$];
        int unsigned       fail_count;

        function new();
            region_base = 64'd0;
            region_size = REGION_SIZE_RST;
            fail_count  = 0;
        endfunction

        // Register write; unused indexes are ignored, size keeps low 17 bits
        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            if (idx == REG_REGION_BASE)
                region_base = data;
            else if (idx == REG_REGION_SIZE)
                region_size = data[16:0];
        endfunction

        // Bound checks, shadow memory update and load extension
        function lsu_resp_t access_outcome(lsu_req_t r);
            lsu_resp_t   res;
            logic [63:0] ea;
            logic [63:0] idx;
            logic [63:0] val;
            logic [63:0] limit;
            logic [64:0] end_x;
            logic [64:0] limit_x;
            int unsigned nbytes;
            int unsigned i;
            res = '{STATUS_FAULT, 64'd0, 1'b0, 5'd0};
            nbytes = 1 << r.size;
            ea = r.base + {{52{r.offset[11]}}, r.offset};
            end_x = {1'b0, ea} + nbytes;
            limit_x = {1'b0, region_base} + region_size;
            limit = limit_x[64] ? 64'hFFFF_FFFF_FFFF_FFFF : limit_x[63:0];
            if (end_x[64] || ea < region_base || end_x[63:0] > limit)
                return res;
            idx = ea - region_base;
            // region may extend past the physical memory
            if (idx > LSU_MEM_BYTES - nbytes)
                return res;
            res.status = STATUS_DONE;
            if (r.kind == KIND_STORE) begin
                for (i = 0; i < nbytes; i++)
                    shadow_mem[idx + i] = r.sdata[8*i +: 8];
                return res;
            end
            val = 64'd0;
            for (i = 0; i < nbytes; i++)
                val[8*i +: 8] = shadow_mem[idx + i];
            if (r.sext && nbytes < 8 && val[8*nbytes-1])
                val = val | ~((64'd1 << (8*nbytes)) - 64'd1);
            res.value = val;
            if (r.rd != 5'd0) begin
                res.we   = 1'b1;
                res.wreg = r.rd;
            end
            return res;
        endfunction

        function void note_request(lsu_req_t r);
            pending_outcomes.push_back(access_outcome(r));
        endfunction

        // Compare one result against the oldest outstanding expectation
        function void check_result(lsu_resp_t got);
            lsu_resp_t exp_r;
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result: status %0d load_value %h", got.status, got.value);
                fail_count++;
                return;
            end
            exp_r = pending_outcomes.pop_front();
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                fail_count++;
            end
            if (got.value !== exp_r.value) begin
                $error("load_value: expected %h, got %h", exp_r.value, got.value);
                fail_count++;
            end
            if (got.we !== exp_r.we) begin
                $error("write_enable: expected %0d, got %0d", exp_r.we, got.we);
                fail_count++;
            end
            if (got.wreg !== exp_r.wreg) begin
                $error("write_reg: expected %0d, got %0d", exp_r.wreg, got.wreg);
                fail_count++;
            end
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

endpackage

// ----- bench/tb_top.sv -----
// Top-level testbench for the load/store unit: stimulus, handshakes and run control.
module tb_top;
    import lsu_pkg::*;
    import lsu_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 16;
    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_kind = 1'b0;
    logic [1:0]           i_size_code = 2'd0;
    logic                 i_sign_extend = 1'b0;
    logic [63:0]          i_base_value = 64'd0;
    logic signed [11:0]   i_offset = 12'sd0;
    logic [63:0]          i_store_data = 64'd0;
    logic [4:0]           i_dest_reg = 5'd0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_status;
    logic [63:0]          o_load_value;
    logic                 o_write_enable;
    logic [4:0]           o_write_reg;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_REGION_BASE;
    logic [63:0]          i_cfg_data = 64'd0;

    lsu_scoreboard sb = new();
    lsu_req_t      seen_req;
    lsu_resp_t     seen_resp;
    int            sender_idle_pct = 0;
    int            sink_stall_pct = 0;
    logic [63:0]   cur_base = 64'd0;
    logic [16:0]   cur_size = REGION_SIZE_RST;
    int unsigned   hot_start = 0;
    int unsigned   cycle_count = 0;

    load_store_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_size_code    (i_size_code),
        .i_sign_extend  (i_sign_extend),
        .i_base_value   (i_base_value),
        .i_offset       (i_offset),
        .i_store_data   (i_store_data),
        .i_dest_reg     (i_dest_reg),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_load_value   (o_load_value),
        .o_write_enable (o_write_enable),
        .o_write_reg    (o_write_reg),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result-side backpressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    // Monitor: every handshake is sampled at the edge where it completes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_register(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready) begin
                seen_req.kind   = i_kind;
                seen_req.size   = t_size'(i_size_code);
                seen_req.sext   = i_sign_extend;
                seen_req.base   = i_base_value;
                seen_req.offset = i_offset;
                seen_req.sdata  = i_store_data;
                seen_req.rd     = i_dest_reg;
                sb.note_request(seen_req);
            end
            if (o_valid && i_ready) begin
                seen_resp.status = o_status;
                seen_resp.value  = o_load_value;
                seen_resp.we     = o_write_enable;
                seen_resp.wreg   = o_write_reg;
                sb.check_result(seen_resp);
            end
        end
    end

    function automatic int unsigned region_span();
        return (cur_size < LSU_MEM_BYTES) ? cur_size : LSU_MEM_BYTES;
    endfunction

    function automatic lsu_req_t make_access(logic kind, t_size size, logic sext,
                                             logic [63:0] base, logic signed [11:0] offset,
                                             logic [63:0] sdata, logic [4:0] rd);
        lsu_req_t r;
        r = '{kind, size, sext, base, offset, sdata, rd};
        return r;
    endfunction

    // Mostly in-region traffic around a hot window so loads see earlier stores;
    // the rest straddles region and memory edges, the top of the address space
    // or is fully random.
    function automatic lsu_req_t random_access();
        lsu_req_t    r;
        logic [63:0] ea;
        int unsigned pick;
        r.kind   = ($urandom_range(99, 0) < 45) ? KIND_STORE : KIND_LOAD;
        r.size   = t_size'($urandom_range(3, 0));
        r.sext   = 1'($urandom_range(1, 0));
        r.offset = 12'($urandom);
        r.sdata  = {$urandom, $urandom};
        r.rd     = 5'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 50)
            ea = cur_base + hot_start + $urandom_range(63, 0);
        else if (pick < 65)
            ea = cur_base + $urandom_range(region_span(), 0);
        else if (pick < 75)
            ea = cur_base + $urandom_range(16, 0) - 64'd8;
        else if (pick < 85)
            ea = cur_base + cur_size + $urandom_range(16, 0) - 64'd12;
        else if (pick < 92)
            ea = cur_base + LSU_MEM_BYTES + $urandom_range(16, 0) - 64'd12;
        else if (pick < 96)
            ea = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(15, 0);
        else
            ea = {$urandom, $urandom};
        r.base = ea - {{52{r.offset[11]}}, r.offset};
        return r;
    endfunction

    // Present one transaction, optionally after an idle gap, and wait for it
    task automatic send_item(lsu_req_t r);
        if ($urandom_range(99, 0) < sender_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < sender_idle_pct);
        end
        i_valid       <= 1'b1;
        i_kind        <= r.kind;
        i_size_code   <= r.size;
        i_sign_extend <= r.sext;
        i_base_value  <= r.base;
        i_offset      <= r.offset;
        i_store_data  <= r.sdata;
        i_dest_reg    <= r.rd;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stop sending and wait until every result is back
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Region setup; spare indexes get junk that must have no effect
    task automatic write_config(logic [63:0] base_val, logic [63:0] size_data);
        put_register(REG_REGION_BASE, base_val);
        put_register(REG_SPARE_A, {$urandom, $urandom});
        put_register(REG_REGION_SIZE, size_data);
        put_register(REG_SPARE_B, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
        cur_base = base_val;
        cur_size = size_data[16:0];
        hot_start = (region_span() > 128) ? $urandom_range(region_span() - 128, 0) : 0;
    endtask

    // One random phase; halfway through the sender holds off until drained
    task automatic run_phase(logic [63:0] base_val, logic [63:0] size_data,
                             int idle_pct, int stall_pct, int count);
        int k;
        write_config(base_val, size_data);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        for (k = 0; k < count; k++) begin
            if (k == count / 2)
                drain();
            send_item(random_access());
        end
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Base 0, full region; size data carries junk above bit 16
        write_config(64'd0, 64'hFFFF_FFFF_FFFF_0000);

        // Directed: extensions, misaligned overlap, memory end, wrap faults
        send_item(make_access(KIND_STORE, SZ_DOUBLE, 1'b0, 64'd0, 12'sd0,
                              64'hF1E2_D3C4_B5A6_9788, 5'd0));
        send_item(make_access(KIND_LOAD, SZ_BYTE,   1'b1, 64'd0, 12'sd0, 64'd0, 5'd1));
        send_item(make_access(KIND_LOAD, SZ_BYTE,   1'b0, 64'd0, 12'sd0, 64'd0, 5'd2));
        send_item(make_access(KIND_LOAD, SZ_HALF,   1'b1, 64'd0, 12'sd0, 64'd0, 5'd3));
        send_item(make_access(KIND_LOAD, SZ_HALF,   1'b0, 64'd0, 12'sd0, 64'd0, 5'd4));
        send_item(make_access(KIND_LOAD, SZ_WORD,   1'b1, 64'd0, 12'sd0, 64'd0, 5'd5));
        send_item(make_access(KIND_LOAD, SZ_WORD,   1'b0, 64'd0, 12'sd0, 64'd0, 5'd31));
        send_item(make_access(KIND_LOAD, SZ_DOUBLE, 1'b1, 64'd0, 12'sd0, 64'd0, 5'd6));
        // load to register zero still returns the value
        send_item(make_access(KIND_LOAD, SZ_DOUBLE, 1'b0, 64'd0, 12'sd0, 64'd0, 5'd0));
        // most negative offset; sign_extend ignored on a store
        send_item(make_access(KIND_STORE, SZ_WORD, 1'b1, 64'd2148, -12'sd2048,
                              64'hFFFF_FFFF_0102_0304, 5'd17));
        send_item(make_access(KIND_STORE, SZ_HALF, 1'b0, 64'd0, 12'sd103,
                              64'h0000_0000_0000_ABCD, 5'd0));
        send_item(make_access(KIND_LOAD, SZ_DOUBLE, 1'b0, 64'd0, 12'sd99, 64'd0, 5'd7));
        // most positive offset, last doubleword of memory
        send_item(make_access(KIND_STORE, SZ_DOUBLE, 1'b0, 64'd63481, 12'sd2047,
                              64'hFFFF_FFFF_FFFF_FFFF, 5'd0));
        send_item(make_access(KIND_LOAD, SZ_DOUBLE, 1'b1, 64'd63481, 12'sd2047, 64'd0, 5'd8));
        send_item(make_access(KIND_STORE, SZ_BYTE, 1'b0, 64'd65535, 12'sd0, 64'h7F, 5'd0));
        send_item(make_access(KIND_LOAD, SZ_BYTE, 1'b1, 64'd65535, 12'sd0, 64'd0, 5'd9));
        // past the region end: faults, memory unchanged; then a load of the last word
        send_item(make_access(KIND_LOAD, SZ_HALF, 1'b0, 64'd65535, 12'sd0, 64'd0, 5'd11));
        send_item(make_access(KIND_STORE, SZ_WORD, 1'b0, 64'd65534, 12'sd0, 64'd0, 5'd0));
        send_item(make_access(KIND_LOAD, SZ_WORD, 1'b0, 64'd65532, 12'sd0, 64'd0, 5'd10));
        // near the top of the address space; an access end may wrap past 2^64
        send_item(make_access(KIND_LOAD, SZ_DOUBLE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 12'sd0,
                              64'd0, 5'd12));
        send_item(make_access(KIND_STORE, SZ_BYTE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, -12'sd1,
                              64'hA5, 5'd0));
        send_item(make_access(KIND_LOAD, SZ_BYTE, 1'b1, 64'd0, -12'sd1, 64'd0, 5'd13));
        send_item(make_access(KIND_STORE, SZ_BYTE, 1'b0, 64'd5, -12'sd5, 64'd0, 5'd0));
        drain();

        run_phase(64'd0, 64'd65536, 0, 0, 300);
        run_phase(64'h0000_0000_8000_0000, 64'd4096, 55, 0, 300);
        // region top overflows: limit saturates
        run_phase(64'hFFFF_FFFF_FFFF_8000, 64'd65536, 0, 55, 300);
        // region bigger than memory
        run_phase(64'd0, 64'h1_FFFF, 32, 32, 300);
        // empty region: everything faults
        run_phase({$urandom, $urandom}, 64'd0, 0, 0, 100);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 55, 0, 250);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 0, 55, 80);
        run_phase(64'h0000_0000_0001_0000, 64'd8, 32, 32, 150);

        if (sb.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lsu_pkg.sv
rtl/lsu_ram.sv
rtl/load_store_unit.sv
rtl/lsu_checker.sv
bench/lsu_tb_pkg.sv
bench/tb_top.sv
